// ===== sv/skf_pkg.sv =====
// ----------------------------------------------------------------------------
// skf_pkg
// Shared types and constants of the scalar Kalman filter: sequencer states,
// gain format, register indexes and register reset values.
// ----------------------------------------------------------------------------
package skf_pkg;

    // Gain is unsigned Q0.16 with one extra bit so that 1.0 is representable
    localparam int GAIN_BITS  = 16;
    localparam int GAIN_WIDTH = GAIN_BITS + 1;
    localparam logic [GAIN_WIDTH-1:0] GAIN_ONE = GAIN_WIDTH'(1) << GAIN_BITS;

    // One quotient bit per division step
    localparam int DIV_STEPS = GAIN_WIDTH;
    localparam int CNT_WIDTH = $clog2(DIV_STEPS);

    // Datapath word sizes
    localparam int STATE_WIDTH = 32;
    localparam int CFG_WIDTH   = 32;
    localparam int EST_WIDTH   = 16;
    localparam int M_TDATA_W   = ((EST_WIDTH + GAIN_WIDTH + 7) / 8) * 8;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROCESS_NOISE = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MEASURE_NOISE = 1'b1;

    // Register reset values (10.0 and 400.0 in Q16.16)
    localparam logic [CFG_WIDTH-1:0] PROCESS_NOISE_RST = 32'd655360;
    localparam logic [CFG_WIDTH-1:0] MEASURE_NOISE_RST = 32'd26214400;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DEN,
        ST_INIT,
        ST_DIV,
        ST_MUL_EST,
        ST_MUL_COV,
        ST_OUT
    } skf_state_t;

endpackage

// ===== sv/scalar_kalman_filter.sv =====
// ----------------------------------------------------------------------------
// scalar_kalman_filter
// One-dimensional Kalman filter in fixed point, one shared multiplier and a
// restoring divider stepped by a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one signed sensor sample per transfer.
//   Output stream (m_*): one result per sample: the rounded estimate and the
//   gain used in that step.
//   Config port: cfg_we / cfg_index / cfg_data write process_noise (index 0)
//   or measure_noise (index 1); write only while idle.
// Sequence:
//   A sample passes through prediction, the gain denominator, divider setup,
//   the 17-step restoring divider (skipped with a zero denominator), two
//   passes through the shared multiplier and the output load; the next
//   sample is taken once the sequencer is back in idle.
//   s_tready is high only while the sequencer is idle.
// Stalls:
//   The result sits in an output register, so a new sample is taken while an
//   earlier result waits; if that result is still not taken when the next
//   one is ready, the sequencer holds until m_tready frees the register.
// Reset:
//   rst_n clears the estimate to zero, the covariance to one and loads the
//   default noise values; both streams go empty.
// ----------------------------------------------------------------------------
module scalar_kalman_filter #(
    parameter int FRAC_BITS    = 16,
    parameter int SAMPLE_WIDTH = 16,
    localparam int S_TDATA_W   = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [S_TDATA_W-1:0]                 s_tdata,   // [SAMPLE_WIDTH-1:0] sample
    // output stream
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [skf_pkg::M_TDATA_W-1:0]        m_tdata,   // [15:0] estimate, [32:16] gain
    // configuration
    input  logic                                 cfg_we,
    input  logic [skf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [skf_pkg::CFG_WIDTH-1:0]        cfg_data
);

    localparam int SW  = skf_pkg::STATE_WIDTH;
    localparam int GW  = skf_pkg::GAIN_WIDTH;
    localparam int GB  = skf_pkg::GAIN_BITS;
    localparam int EW  = skf_pkg::EST_WIDTH;
    localparam int NUM_W  = SW + GB + 1;          // pm * 2^16 + den / 2
    localparam int REM_W  = SW + 1;               // remainder below den
    localparam int MB_W   = SW + 2;               // signed multiplier operand
    localparam int PROD_W = GW + 1 + MB_W;        // signed product
    localparam int SUM_W  = SW + 5;               // estimate plus delta

    localparam logic signed [63:0] I32_MAX_W = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN_W = -64'sd2147483648;
    localparam logic signed [SUM_W-1:0] I32_MAX_S = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] I32_MIN_S = SUM_W'(-64'sd2147483648);
    localparam logic signed [SW:0] EST_MAX = (SW+1)'(32767);
    localparam logic signed [SW:0] EST_MIN = (SW+1)'(-32768);
    localparam logic signed [SW:0] EST_HALF = (SW+1)'(1) << (FRAC_BITS - 1);
    localparam logic signed [PROD_W-1:0] PROD_HALF = PROD_W'(1) << (GB - 1);
    localparam logic [SW-1:0] COV_RST = SW'(1) << FRAC_BITS;
    localparam logic [skf_pkg::CNT_WIDTH-1:0] CNT_LAST =
        skf_pkg::CNT_WIDTH'(skf_pkg::DIV_STEPS - 1);

    skf_pkg::skf_state_t state_reg, state_next;

    logic [SW-1:0]                 q_noise_reg, r_noise_reg;
    logic signed [SW-1:0]          est_reg;
    logic [SW-1:0]                 cov_reg;
    logic [SAMPLE_WIDTH-1:0]       sample_reg;
    logic [SW-1:0]                 pm_reg;
    logic [SW:0]                   den_reg;
    logic [REM_W-1:0]              rem_reg;
    logic [GB:0]                   num_lo_reg;
    logic [GW-1:0]                 q_reg;
    logic [skf_pkg::CNT_WIDTH-1:0] cnt_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          m_tvalid_reg;
    logic [skf_pkg::M_TDATA_W-1:0] m_tdata_reg;

    logic                          in_xfer;
    logic                          out_load;

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            skf_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = skf_pkg::ST_PRED;
            end
            skf_pkg::ST_PRED:    state_next = skf_pkg::ST_DEN;
            skf_pkg::ST_DEN:     state_next = skf_pkg::ST_INIT;
            skf_pkg::ST_INIT:
            begin
                if (den_reg == '0)
                    state_next = skf_pkg::ST_MUL_EST;
                else
                    state_next = skf_pkg::ST_DIV;
            end
            skf_pkg::ST_DIV:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = skf_pkg::ST_MUL_EST;
            end
            skf_pkg::ST_MUL_EST: state_next = skf_pkg::ST_MUL_COV;
            skf_pkg::ST_MUL_COV: state_next = skf_pkg::ST_OUT;
            skf_pkg::ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                    state_next = skf_pkg::ST_IDLE;
            end
            default:             state_next = skf_pkg::ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs
    // ------------------------------------------------------------------
    always_comb
    begin
        s_tready = 1'b0;
        out_load = 1'b0;
        unique case (state_reg)
            skf_pkg::ST_IDLE: s_tready = 1'b1;
            skf_pkg::ST_OUT:  out_load = !m_tvalid_reg || m_tready;
            default:
            begin
                s_tready = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    assign in_xfer = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Prediction: saturating covariance add, then the gain denominator
    // ------------------------------------------------------------------
    logic [SW:0]    pm_sum;
    logic [SW-1:0]  pm_sat;
    logic [NUM_W-1:0] num_full;

    assign pm_sum   = {1'b0, cov_reg} + {1'b0, q_noise_reg};
    assign pm_sat   = pm_sum[SW] ? '1 : pm_sum[SW-1:0];
    assign num_full = {1'b0, pm_reg, {GB{1'b0}}} + NUM_W'(den_reg >> 1);

    // ------------------------------------------------------------------
    // Divider step: one quotient bit per cycle
    // ------------------------------------------------------------------
    logic [REM_W:0] div_shift;
    logic [REM_W:0] div_trial;
    logic           div_ge;

    assign div_shift = {rem_reg, num_lo_reg[GB]};
    assign div_trial = div_shift - {1'b0, den_reg};
    assign div_ge    = !div_trial[REM_W];

    // ------------------------------------------------------------------
    // Shared multiplier: gain * (z - est), then pm * (1 - gain)
    // ------------------------------------------------------------------
    logic signed [63:0]       z_wide;
    logic signed [SW-1:0]     z_val;
    logic signed [SW:0]       diff;
    logic [GW-1:0]            mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] mul_p;

    assign z_wide = 64'(signed'(sample_reg)) <<< FRAC_BITS;
    always_comb
    begin
        if (z_wide > I32_MAX_W)
            z_val = I32_MAX_W[SW-1:0];
        else if (z_wide < I32_MIN_W)
            z_val = I32_MIN_W[SW-1:0];
        else
            z_val = z_wide[SW-1:0];
    end
    assign diff = {z_val[SW-1], z_val} - {est_reg[SW-1], est_reg};

    always_comb
    begin
        if (state_reg == skf_pkg::ST_MUL_EST)
        begin
            mul_a = q_reg;
            mul_b = {diff[SW], diff};
        end
        else
        begin
            mul_a = skf_pkg::GAIN_ONE - q_reg;
            mul_b = {2'b00, pm_reg};
        end
    end
    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    // ------------------------------------------------------------------
    // Estimate update (rounded delta, saturated sum) and covariance update
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] prod_rnd;
    logic signed [SUM_W-1:0]  est_sum;
    logic signed [SW-1:0]     est_sat;

    assign prod_rnd = prod_reg + PROD_HALF;
    assign est_sum  = SUM_W'(est_reg) + SUM_W'(prod_rnd >>> GB);
    always_comb
    begin
        if (est_sum > I32_MAX_S)
            est_sat = I32_MAX_S[SW-1:0];
        else if (est_sum < I32_MIN_S)
            est_sat = I32_MIN_S[SW-1:0];
        else
            est_sat = est_sum[SW-1:0];
    end

    // ------------------------------------------------------------------
    // Output rounding to an integer sample
    // ------------------------------------------------------------------
    logic signed [SW:0]   est_half;
    logic signed [SW:0]   est_int;
    logic [EW-1:0]        est_out;

    assign est_half = {est_reg[SW-1], est_reg} + EST_HALF;
    assign est_int  = est_half >>> FRAC_BITS;
    always_comb
    begin
        if (est_int > EST_MAX)
            est_out = EST_MAX[EW-1:0];
        else if (est_int < EST_MIN)
            est_out = EST_MIN[EW-1:0];
        else
            est_out = est_int[EW-1:0];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= skf_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            q_noise_reg  <= skf_pkg::PROCESS_NOISE_RST;
            r_noise_reg  <= skf_pkg::MEASURE_NOISE_RST;
            est_reg      <= '0;
            cov_reg      <= COV_RST;
        end
        else
        begin
            state_reg <= state_next;

            // config writes
            if (cfg_we)
            begin
                unique case (cfg_index)
                    skf_pkg::CFG_PROCESS_NOISE: q_noise_reg <= cfg_data;
                    skf_pkg::CFG_MEASURE_NOISE: r_noise_reg <= cfg_data;
                    default:                    q_noise_reg <= q_noise_reg;
                endcase
            end

            // filter state
            if (state_reg == skf_pkg::ST_MUL_COV)
                est_reg <= est_sat;
            if (state_reg == skf_pkg::ST_OUT && out_load)
                cov_reg <= prod_rnd[GB+SW-1:GB];

            // output valid
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_xfer)
            sample_reg <= s_tdata[SAMPLE_WIDTH-1:0];

        unique case (state_reg)
            skf_pkg::ST_PRED:
                pm_reg <= pm_sat;
            skf_pkg::ST_DEN:
                den_reg <= {1'b0, pm_reg} + {1'b0, r_noise_reg};
            skf_pkg::ST_INIT:
            begin
                rem_reg    <= REM_W'(num_full[NUM_W-1:GB+1]);
                num_lo_reg <= num_full[GB:0];
                cnt_reg    <= '0;
                q_reg      <= (den_reg == '0) ? skf_pkg::GAIN_ONE : '0;
            end
            skf_pkg::ST_DIV:
            begin
                rem_reg    <= div_ge ? div_trial[REM_W-1:0] : div_shift[REM_W-1:0];
                num_lo_reg <= {num_lo_reg[GB-1:0], 1'b0};
                q_reg      <= {q_reg[GW-2:0], div_ge};
                cnt_reg    <= cnt_reg + 1'b1;
            end
            skf_pkg::ST_MUL_EST,
            skf_pkg::ST_MUL_COV:
                prod_reg <= mul_p;
            default:
                prod_reg <= prod_reg;
        endcase

        if (out_load)
            m_tdata_reg <= skf_pkg::M_TDATA_W'({q_reg, est_out});
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sim/tb_scalar_kalman_filter.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_scalar_kalman_filter
// Self-checking bench for the scalar Kalman filter. A fixed-point filter
// model in the bench follows every accepted sample and queues the expected
// estimate and gain. Each result transfer is checked against the oldest
// entry. Directed tests cover sample extremes, the zero-denominator gain,
// covariance saturation and a long output stall. Random phases then sweep
// the noise settings with bursty input and a stalling output.
// ----------------------------------------------------------------------------
module tb_scalar_kalman_filter;

    localparam int     FRAC         = 16;
    localparam int     SMP_W        = 16;
    localparam int     DRAIN_CYCLES = 40;
    localparam int     HOLD_CYCLES  = 600;
    localparam int     CYCLE_LIMIT  = 1000000;
    localparam int     PHASE_ITEMS  = 200;
    localparam longint GAIN_UNIT    = longint'(1) << skf_pkg::GAIN_BITS;
    localparam longint S32_MIN      = -64'sd2147483648;
    localparam longint S32_MAX      = 64'sd2147483647;
    localparam longint U32_MAX      = 64'sd4294967295;

    typedef struct {
        logic signed [skf_pkg::EST_WIDTH-1:0] estimate;
        logic [skf_pkg::GAIN_WIDTH-1:0]       gain;
    } kalman_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [SMP_W-1:0]                s_tdata;    // [15:0] sample
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [skf_pkg::M_TDATA_W-1:0]   m_tdata;    // [15:0] estimate, [32:16] gain
    logic                            cfg_we;
    logic [skf_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [skf_pkg::CFG_WIDTH-1:0]   cfg_data;

    // Filter model state and its copy of the noise registers
    logic signed [31:0]            filt_est;
    logic [31:0]                   filt_cov;
    logic [skf_pkg::CFG_WIDTH-1:0] q_noise;
    logic [skf_pkg::CFG_WIDTH-1:0] r_noise;

    kalman_result_t         pending_results[$];
    kalman_result_t         oldest;
    int                     err_count   = 0;
    int                     cycle_count = 0;

    // Pacing knobs
    int                     burst_left   = 0;
    int                     gap_max      = 0;
    int                     stall_pct    = 0;
    logic                   rx_hold      = 1'b0;
    event                   hold_off_ev;

    scalar_kalman_filter #(
        .FRAC_BITS    (FRAC),
        .SAMPLE_WIDTH (SMP_W)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic longint clamp_l(input longint v, input longint lo, input longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        err_count++;
    endtask

    // One filter step: predict, gain, estimate and covariance update
    task automatic kalman_advance(input logic signed [SMP_W-1:0] smp);
        longint pm;
        longint den;
        longint gn;
        longint z;
        longint diff;
        longint delta;
        longint est;
        longint pn;
        longint rnd;
        kalman_result_t res;
        pm = longint'({32'd0, filt_cov}) + longint'({32'd0, q_noise});
        if (pm > U32_MAX)
            pm = U32_MAX;
        den = pm + longint'({32'd0, r_noise});
        if (den == 0)
            gn = GAIN_UNIT;
        else
            gn = ((pm <<< skf_pkg::GAIN_BITS) + den / 2) / den;
        z     = clamp_l(longint'(smp) * (longint'(1) <<< FRAC), S32_MIN, S32_MAX);
        diff  = z - longint'(filt_est);
        delta = (gn * diff + GAIN_UNIT / 2) >>> skf_pkg::GAIN_BITS;
        est   = clamp_l(longint'(filt_est) + delta, S32_MIN, S32_MAX);
        filt_est = est[31:0];
        pn = (pm * (GAIN_UNIT - gn) + GAIN_UNIT / 2) >>> skf_pkg::GAIN_BITS;
        pn = clamp_l(pn, 0, U32_MAX);
        filt_cov = pn[31:0];
        rnd = clamp_l((est + (longint'(1) <<< (FRAC - 1))) >>> FRAC, -32768, 32767);
        res.estimate = rnd[skf_pkg::EST_WIDTH-1:0];
        res.gain     = gn[skf_pkg::GAIN_WIDTH-1:0];
        pending_results.push_back(res);
    endtask

    // Offer one sample and wait for its transfer; s_tvalid stays high after
    task automatic send_sample(input logic signed [SMP_W-1:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do
            @(posedge clk);
        while (!s_tready);
        kalman_advance(smp);
    endtask

    // Sender in bursts with random gaps between them
    task automatic send_paced(input logic signed [SMP_W-1:0] smp);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(gap_max);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        send_sample(smp);
    endtask

    // Register write once every pending result has come back
    task automatic write_noise_reg(input logic [skf_pkg::CFG_INDEX_W-1:0] idx,
                                   input logic [skf_pkg::CFG_WIDTH-1:0] val);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0 || !s_tready)
            @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            skf_pkg::CFG_PROCESS_NOISE: q_noise = val;
            skf_pkg::CFG_MEASURE_NOISE: r_noise = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_noise(input logic [skf_pkg::CFG_WIDTH-1:0] q,
                             input logic [skf_pkg::CFG_WIDTH-1:0] r);
        write_noise_reg(skf_pkg::CFG_PROCESS_NOISE, q);
        write_noise_reg(skf_pkg::CFG_MEASURE_NOISE, r);
    endtask

    // Result checker and output-side stall pattern
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch($sformatf("result transfer with no pending sample, data %h",
                                              m_tdata));
                end
                else
                begin
                    oldest = pending_results.pop_front();
                    if (m_tdata[skf_pkg::EST_WIDTH-1:0] !== oldest.estimate)
                        report_mismatch($sformatf("estimate %0d, expected %0d",
                                                  $signed(m_tdata[skf_pkg::EST_WIDTH-1:0]),
                                                  oldest.estimate));
                    if (m_tdata[skf_pkg::EST_WIDTH +: skf_pkg::GAIN_WIDTH] !== oldest.gain)
                        report_mismatch($sformatf("gain %0d, expected %0d",
                                        m_tdata[skf_pkg::EST_WIDTH +: skf_pkg::GAIN_WIDTH],
                                        oldest.gain));
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long output hold-off, timed here so the sender keeps pushing meanwhile
    initial
    begin
        forever
        begin
            @(hold_off_ev);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // Full-scale samples and sign flips on the reset noise settings
    task automatic test_sample_extremes();
        send_sample(16'sd0);
        send_sample(16'sd32767);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(-16'sd32768);
        send_sample(-16'sd1);
        send_sample(16'sd1);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd0);
    endtask

    // No noise at all: gain hits one, covariance drops to zero, then the
    // denominator is zero and the gain is defined as one
    task automatic test_zero_denominator();
        set_noise(32'd0, 32'd0);
        send_sample(16'sd1234);
        send_sample(-16'sd32768);
        send_sample(16'sd32767);
        send_sample(16'sd7);
    endtask

    // Predicted covariance saturates at the top of the unsigned range
    task automatic test_cov_saturation();
        set_noise(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_sample(16'sd32767);
        send_sample(-16'sd32768);
        send_sample(16'sd100);
        set_noise(32'hFFFF_FFFF, 32'd0);
        send_sample(-16'sd500);
        send_sample(16'sd32767);
        set_noise(32'd1, 32'd1);
        send_sample(16'sd3);
        send_sample(-16'sd3);
    endtask

    // Output held off for a long stretch while samples keep coming
    task automatic test_output_backpressure();
        set_noise(skf_pkg::PROCESS_NOISE_RST, skf_pkg::MEASURE_NOISE_RST);
        stall_pct = 0;
        -> hold_off_ev;
        for (int i = 0; i < 12; i++)
            send_sample(SMP_W'($urandom));
    endtask

    // Random phases over noise settings, sample patterns and pacing
    task automatic test_random_phases();
        logic [skf_pkg::CFG_WIDTH-1:0] q;
        logic [skf_pkg::CFG_WIDTH-1:0] r;
        int level;
        int span;
        int v;
        for (int ph = 0; ph < 9; ph++)
        begin
            case (ph)
                0: begin q = skf_pkg::PROCESS_NOISE_RST; r = skf_pkg::MEASURE_NOISE_RST; end
                1: begin q = 32'd0;             r = 32'hFFFF_FFFF;     end
                2: begin q = 32'hFFFF_FFFF;     r = 32'd0;             end
                3: begin q = 32'hFFFF_FFFF;     r = 32'hFFFF_FFFF;     end
                4: begin q = 32'd0;             r = 32'd0;             end
                5: begin q = $urandom_range(0, 32'h000F_FFFF);
                         r = $urandom_range(32'h0001_0000, 32'h1000_0000); end
                6: begin q = $urandom_range(0, 255); r = $urandom_range(0, 255); end
                default: begin q = $urandom; r = $urandom; end
            endcase
            set_noise(q, r);
            gap_max   = (ph % 3 == 0) ? 0 : ((ph % 3 == 1) ? 4 : 30);
            stall_pct = (ph % 4) * 28;
            level     = $urandom_range(0, 65535) - 32768;
            span      = 1 << $urandom_range(0, 14);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                case ($urandom_range(9))
                    0, 1:    v = $urandom_range(0, 65535) - 32768;
                    2:       v = ($urandom_range(1) != 0) ? 32767 : -32768;
                    3:       begin
                                 level = $urandom_range(0, 65535) - 32768;
                                 v = level;
                             end
                    default: v = level + $urandom_range(0, 2 * span) - span;
                endcase
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
                send_paced(v[SMP_W-1:0]);
            end
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        q_noise   = skf_pkg::PROCESS_NOISE_RST;
        r_noise   = skf_pkg::MEASURE_NOISE_RST;
        filt_est  = '0;
        filt_cov  = 32'd1 << FRAC;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        stall_pct = 20;
        test_sample_extremes();
        test_zero_denominator();
        test_cov_saturation();
        test_output_backpressure();
        test_random_phases();

        // Drain and let any stray result show up
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
